// File: design/srlp_pkg.sv
// Shared types and constants of the sound register log parser.
// Used by srlp_front, srlp_queue, srlp_back and sound_register_log_parser.
`default_nettype none
package srlp_pkg;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_WAIT  = 2'd1;
   localparam logic [1:0] KIND_LOOP  = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic CSR_SLOT_ENABLE  = 1'b0;
   localparam logic CSR_LOOP_PRESENT = 1'b1;

   localparam logic [7:0] OP_WAIT1  = 8'hFF;
   localparam logic [7:0] OP_VARINT = 8'hFE;
   localparam logic [7:0] OP_LOOP   = 8'hFD;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  slot;
      logic [8:0]  reg_addr;
      logic [7:0]  reg_data;
      logic [32:0] wait_syncs;
   } cmd_type;

endpackage
`default_nettype wire

// File: design/srlp_front.sv
// Front end: parses the byte stream and pushes classified commands.
// Depends on srlp_pkg.
`default_nettype none
module srlp_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     fire,
   input  wire  [7:0]              byte_in,
   input  wire                     loop_present,
   output logic                    push,
   output srlp_pkg::cmd_type       push_cmd
);
   import srlp_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_ADDR   = 3'd1;
   localparam logic [2:0] PH_DATA   = 3'd2;
   localparam logic [2:0] PH_VARINT = 3'd3;
   localparam logic [2:0] PH_HALT   = 3'd4;
   localparam logic [2:0] GRP_MAX   = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  slot_ff, slot_in;
   logic        bank_ff, bank_in;
   logic [7:0]  addr_ff, addr_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  grp_ff, grp_in;
   logic [31:0] contrib;
   logic [31:0] acc_next;

   always_comb begin
      case (grp_ff)
         3'd0:    contrib = {25'd0, byte_in[6:0]};
         3'd1:    contrib = {18'd0, byte_in[6:0], 7'd0};
         3'd2:    contrib = {11'd0, byte_in[6:0], 14'd0};
         3'd3:    contrib = {4'd0, byte_in[6:0], 21'd0};
         3'd4:    contrib = {byte_in[3:0], 28'd0};
         default: contrib = 32'd0;
      endcase
      acc_next = acc_ff | contrib;
   end

   always_comb begin
      phase_in = phase_ff;
      slot_in  = slot_ff;
      bank_in  = bank_ff;
      addr_in  = addr_ff;
      acc_in   = acc_ff;
      grp_in   = grp_ff;
      push     = 1'b0;
      push_cmd = '0;
      if (fire) begin
         case (phase_ff)
            PH_ADDR: begin
               addr_in  = byte_in;
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               phase_in          = PH_IDLE;
               push              = 1'b1;
               push_cmd.kind     = KIND_WRITE;
               push_cmd.slot     = slot_ff;
               push_cmd.reg_addr = {bank_ff, addr_ff};
               push_cmd.reg_data = byte_in;
            end
            PH_VARINT: begin
               acc_in = acc_next;
               if (grp_ff < GRP_MAX) begin
                  grp_in = grp_ff + 3'd1;
               end
               if (!byte_in[7]) begin
                  phase_in            = PH_IDLE;
                  push                = 1'b1;
                  push_cmd.kind       = KIND_WAIT;
                  push_cmd.wait_syncs = {1'b0, acc_next} + 33'd2;
               end
            end
            PH_IDLE: begin
               if (!byte_in[7]) begin
                  slot_in  = byte_in[6:1];
                  bank_in  = byte_in[0];
                  phase_in = PH_ADDR;
               end else if (byte_in == OP_WAIT1) begin
                  push                = 1'b1;
                  push_cmd.kind       = KIND_WAIT;
                  push_cmd.wait_syncs = 33'd1;
               end else if (byte_in == OP_VARINT) begin
                  acc_in   = '0;
                  grp_in   = '0;
                  phase_in = PH_VARINT;
               end else if (byte_in == OP_LOOP && loop_present) begin
                  push          = 1'b1;
                  push_cmd.kind = KIND_LOOP;
               end else begin
                  push          = 1'b1;
                  push_cmd.kind = KIND_END;
                  phase_in      = PH_HALT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         slot_ff  <= '0;
         bank_ff  <= 1'b0;
         addr_ff  <= '0;
         acc_ff   <= '0;
         grp_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         bank_ff  <= bank_in;
         addr_ff  <= addr_in;
         acc_ff   <= acc_in;
         grp_ff   <= grp_in;
      end
   end

endmodule
`default_nettype wire

// File: design/srlp_queue.sv
// Two-entry command queue between the parser front end and the back end.
// Depends on srlp_pkg.
`default_nettype none
module srlp_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  srlp_pkg::cmd_type       push_cmd,
   input  wire                     pop,
   output logic                    full,
   output logic                    q_valid,
   output srlp_pkg::cmd_type       q_cmd
);
   import srlp_pkg::*;

   cmd_type     mem [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = mem[rd_ff];

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: design/srlp_back.sv
// Back end: filters writes to disabled slots and holds the result register.
// Depends on srlp_pkg.
`default_nettype none
module srlp_back #(
   parameter int SLOT_COUNT = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [SLOT_COUNT-1:0]   slot_enable,
   input  wire                     q_valid,
   input  srlp_pkg::cmd_type       q_cmd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output srlp_pkg::cmd_type       rsp_cmd
);
   import srlp_pkg::*;

   logic            valid_ff, valid_in;
   cmd_type         cmd_ff;
   logic            room;
   logic            enabled;
   logic            keep;
   logic [SLOT_COUNT-1:0] sel;

   assign sel     = SLOT_COUNT'(1) << q_cmd.slot;
   assign enabled = |(slot_enable & sel);
   assign room    = !valid_ff || !rsp_stall;
   assign pop     = q_valid && room;
   assign keep    = pop && !(q_cmd.kind == KIND_WRITE && !enabled);

   always_comb begin
      if (keep) begin
         valid_in = 1'b1;
      end else if (room) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_cmd   = cmd_ff;

   always_ff @(posedge clock) begin
      if (keep) begin
         cmd_ff <= q_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

// File: design/sound_register_log_parser.sv
// Sound chip register log parser, top level.
// Depends on srlp_pkg, srlp_front, srlp_queue and srlp_back.
//
// Usage: log bytes enter on req_byte_in with req_valid/req_stall; a
// transaction moves at an edge with valid high and stall low. Each byte
// yields zero or one result on the rsp_ channel (kind, slot, reg_addr,
// reg_data, wait_syncs), taken when rsp_valid is high and rsp_stall low.
// Throughput is one byte per cycle while req_stall is low. A completed
// result is written into the two-entry queue at the edge that accepts its
// last byte, then moves into the output register, raising rsp_valid, once
// that register has room. Writes to disabled slots are dropped in the back
// end. When the receiver stalls, the output register holds, the queue fills,
// and req_stall rises once both queue entries are occupied. Registers are
// to be written through csr_wen/csr_addr/csr_wdata only while idle; the
// block does not enforce this. Reset clears the parser to idle, empties
// the queue and output, sets the slot enable mask to 1 and clears
// loop_present. After an end result the parser ignores all bytes until reset.
`default_nettype none
module sound_register_log_parser #(
   parameter int SLOT_COUNT = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [5:0]  rsp_slot,
   output logic [8:0]  rsp_reg_addr,
   output logic [7:0]  rsp_reg_data,
   output logic [32:0] rsp_wait_syncs,
   input  wire         csr_wen,
   input  wire         csr_addr,
   input  wire  [63:0] csr_wdata
);
   import srlp_pkg::*;

   logic [SLOT_COUNT-1:0] enable_ff;
   logic                  loop_ff;
   logic                  fire;
   logic                  push;
   cmd_type               push_cmd;
   logic                  pop;
   logic                  full;
   logic                  q_valid;
   cmd_type               q_cmd;
   cmd_type               rsp_cmd;

   assign req_stall = full;
   assign fire      = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= SLOT_COUNT'(1);
         loop_ff   <= 1'b0;
      end else if (csr_wen) begin
         if (csr_addr == CSR_SLOT_ENABLE) begin
            enable_ff <= csr_wdata[SLOT_COUNT-1:0];
         end else if (csr_addr == CSR_LOOP_PRESENT) begin
            loop_ff <= csr_wdata[0];
         end
      end
   end

   srlp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .byte_in      (req_byte_in),
      .loop_present (loop_ff),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   srlp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   srlp_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .slot_enable (enable_ff),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_cmd     (rsp_cmd)
   );

   assign rsp_kind       = rsp_cmd.kind;
   assign rsp_slot       = rsp_cmd.slot;
   assign rsp_reg_addr   = rsp_cmd.reg_addr;
   assign rsp_reg_data   = rsp_cmd.reg_data;
   assign rsp_wait_syncs = rsp_cmd.wait_syncs;

endmodule
`default_nettype wire

// File: bench/sound_register_log_parser_checker.sv
`timescale 1ns / 1ps
// Result checker for sound_register_log_parser: follows accepted log bytes and register
// writes, predicts each command, and compares it with the result transactions in order.
// Depends on srlp_pkg; instantiated beside the parser by sound_register_log_parser_tb.
module sound_register_log_parser_checker #(
   parameter int SLOT_COUNT = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire  [7:0]  req_byte_in,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire  [1:0]  rsp_kind,
   input  wire  [5:0]  rsp_slot,
   input  wire  [8:0]  rsp_reg_addr,
   input  wire  [7:0]  rsp_reg_data,
   input  wire  [32:0] rsp_wait_syncs,
   input  wire         csr_wen,
   input  wire         csr_addr,
   input  wire  [63:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   import srlp_pkg::*;

   typedef enum logic [2:0] {
      PARSE_IDLE, PARSE_ADDR, PARSE_DATA, PARSE_VARINT, PARSE_HALTED
   } parse_state_type;

   logic [63:0]     slot_enables;
   logic            loop_enabled;
   parse_state_type parse_state;
   logic [5:0]      open_slot;
   logic            open_bank;
   logic [7:0]      open_addr;
   logic [31:0]     varint_value;
   logic [5:0]      varint_pos;
   cmd_type         expected_cmds[$];
   int              mismatches = 0;

   function automatic bit parse_byte(input logic [7:0] b, output cmd_type cmd);
      logic [31:0] group_bits;
      cmd = '0;
      group_bits = {25'd0, b[6:0]};
      case (parse_state)
         PARSE_ADDR: begin
            open_addr = b;
            parse_state = PARSE_DATA;
            return 1'b0;
         end
         PARSE_DATA: begin
            parse_state = PARSE_IDLE;
            if (int'(open_slot) >= SLOT_COUNT || !slot_enables[open_slot])
               return 1'b0;
            cmd.kind = KIND_WRITE;
            cmd.slot = open_slot;
            cmd.reg_addr = {open_bank, open_addr};
            cmd.reg_data = b;
            return 1'b1;
         end
         PARSE_VARINT: begin
            // groups past bit 31 are dropped, position saturates
            if (varint_pos < 6'd32)
               varint_value |= group_bits << varint_pos;
            if (varint_pos < 6'd35)
               varint_pos += 6'd7;
            if (b[7])
               return 1'b0;
            parse_state = PARSE_IDLE;
            cmd.kind = KIND_WAIT;
            cmd.wait_syncs = {1'b0, varint_value} + 33'd2;
            return 1'b1;
         end
         PARSE_IDLE: ;
         default: return 1'b0;
      endcase

      if (!b[7]) begin
         open_slot = b[6:1];
         open_bank = b[0];
         parse_state = PARSE_ADDR;
         return 1'b0;
      end
      if (b == OP_WAIT1) begin
         cmd.kind = KIND_WAIT;
         cmd.wait_syncs = 33'd1;
         return 1'b1;
      end
      if (b == OP_VARINT) begin
         varint_value = '0;
         varint_pos = '0;
         parse_state = PARSE_VARINT;
         return 1'b0;
      end
      if (b == OP_LOOP && loop_enabled) begin
         cmd.kind = KIND_LOOP;
         return 1'b1;
      end
      parse_state = PARSE_HALTED;
      cmd.kind = KIND_END;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : monitor
      cmd_type want;
      cmd_type seen;
      if (reset) begin
         slot_enables = 64'd1;
         loop_enabled = 1'b0;
         parse_state = PARSE_IDLE;
         open_slot = '0;
         open_bank = 1'b0;
         open_addr = '0;
         varint_value = '0;
         varint_pos = '0;
         expected_cmds.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_kind, rsp_slot, rsp_reg_addr, rsp_reg_data, rsp_wait_syncs};
            if (expected_cmds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: kind %0d slot %0d addr 0x%03h data 0x%02h",
                           seen.kind, seen.slot, seen.reg_addr, seen.reg_data);
            end else begin
               want = expected_cmds.pop_front();
               if (seen.kind !== want.kind || seen.slot !== want.slot ||
                   seen.reg_addr !== want.reg_addr || seen.reg_data !== want.reg_data ||
                   seen.wait_syncs !== want.wait_syncs) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected kind %0d slot %0d addr 0x%03h data 0x%02h",
                              want.kind, want.slot, want.reg_addr, want.reg_data,
                              " wait %0d", want.wait_syncs);
                     $display("          got      kind %0d slot %0d addr 0x%03h data 0x%02h",
                              seen.kind, seen.slot, seen.reg_addr, seen.reg_data,
                              " wait %0d", seen.wait_syncs);
                  end
               end
            end
         end
         if (csr_wen) begin
            if (csr_addr == CSR_SLOT_ENABLE)
               slot_enables = csr_wdata;
            else
               loop_enabled = csr_wdata[0];
         end
         if (req_valid && !req_stall) begin
            if (parse_byte(req_byte_in, want))
               expected_cmds.push_back(want);
         end
      end
      pending_count <= expected_cmds.size();
      fail_count <= mismatches;
   end

endmodule

// File: bench/sound_register_log_parser_tb.sv
`timescale 1ns / 1ps
// Top of the sound_register_log_parser bench: clock, reset, log byte stimulus, register
// writes and result back-pressure. Needs srlp_pkg, the parser RTL and the checker module.
module sound_register_log_parser_tb;
   import srlp_pkg::*;

   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BYTES   = 310;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 64;
   localparam int CYCLE_LIMIT   = 250000;

   // reset defaults: writes on slot 0 both banks, slot 63 dropped, waits incl. widest varint
   localparam int OPENING_LEN = 20;
   localparam logic [0:OPENING_LEN-1][7:0] OPENING_LOG = {
      8'h00, 8'h00, 8'h00,
      8'h01, 8'hFF, 8'hFF,
      8'h7F, 8'h5A, 8'hA5,
      OP_WAIT1,
      OP_VARINT, 8'h00,
      OP_VARINT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F
   };
   // all slots enabled, loop configured
   localparam int LOOP_LEN = 4;
   localparam logic [0:LOOP_LEN-1][7:0] LOOP_LOG = {8'h7F, 8'h12, 8'h34, OP_LOOP};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_byte_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [5:0]  rsp_slot;
   logic [8:0]  rsp_reg_addr;
   logic [7:0]  rsp_reg_data;
   logic [32:0] rsp_wait_syncs;
   logic        csr_wen;
   logic        csr_addr;
   logic [63:0] csr_wdata;

   int          fail_count;
   int          pending_count;
   int unsigned cycle_count;
   int unsigned log_bytes;
   bit          no_idle = 1'b0;
   bit          hold_off_req = 1'b0;
   bit          loop_on = 1'b0;

   sound_register_log_parser u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_byte_in(req_byte_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_slot(rsp_slot), .rsp_reg_addr(rsp_reg_addr), .rsp_reg_data(rsp_reg_data),
      .rsp_wait_syncs(rsp_wait_syncs),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   sound_register_log_parser_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_byte_in(req_byte_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_slot(rsp_slot), .rsp_reg_addr(rsp_reg_addr), .rsp_reg_data(rsp_reg_data),
      .rsp_wait_syncs(rsp_wait_syncs),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // result side: random stall per transaction (none in no-idle phases), one long hold-off on request
   initial begin
      int stall_cycles;
      forever begin
         stall_cycles = no_idle ? 0 : $urandom_range(0, 5);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_cycles = HOLD_CYCLES;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (req_stall);
      log_bytes++;
   endtask

   task automatic send_random_command();
      int          pick;
      int          groups;
      logic [7:0]  r;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r = 8'($urandom_range(0, 127));
         send_byte(r);
         r = 8'($urandom);
         send_byte(r);
         r = 8'($urandom);
         send_byte(r);
      end else if (pick < 70 || (pick >= 95 && !loop_on)) begin
         send_byte(OP_WAIT1);
      end else if (pick < 95) begin
         groups = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
         send_byte(OP_VARINT);
         repeat (groups - 1) begin
            r = 8'($urandom);
            send_byte(r | 8'h80);
         end
         r = 8'($urandom);
         send_byte(r & 8'h7F);
      end else begin
         send_byte(OP_LOOP);
      end
   endtask

   // wait out every expected result, then the pipeline latency
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [63:0] mask, input bit loop_flag);
      csr_wen <= 1'b1;
      csr_addr <= CSR_SLOT_ENABLE;
      csr_wdata <= mask;
      @(posedge clock);
      csr_addr <= CSR_LOOP_PRESENT;
      csr_wdata <= {63'd0, loop_flag};
      @(posedge clock);
      csr_wen <= 1'b0;
      loop_on = loop_flag;
   endtask

   initial begin
      logic [63:0] mask;
      logic [7:0]  r;
      bit          hold_armed;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_byte_in <= '0;
      csr_wen <= 1'b0;
      csr_addr <= CSR_SLOT_ENABLE;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < OPENING_LEN; i++)
         send_byte(OPENING_LOG[i]);
      drain();
      load_config('1, 1'b1);
      for (int i = 0; i < LOOP_LEN; i++)
         send_byte(LOOP_LOG[i]);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         mask = {$urandom, $urandom};
         if (ph == 1)
            mask = '0;
         if (ph == 2)
            mask = '1;
         if (ph == 5)
            mask = 64'd1;
         load_config(mask, (ph % 2) == 0);
         no_idle = (ph % 3) == 1;
         hold_armed = (ph % 3) == 0;
         log_bytes = 0;
         while (log_bytes < PHASE_BYTES) begin
            if (hold_armed && log_bytes >= PHASE_BYTES / 3) begin
               hold_off_req = 1'b1;
               hold_armed = 1'b0;
            end
            send_random_command();
         end
      end

      // end of log, then bytes the halted parser must ignore
      drain();
      no_idle = 1'b0;
      load_config({$urandom, $urandom}, 1'b0);
      r = 8'($urandom_range(8'h80, 8'hFC));
      send_byte($urandom_range(0, 1) ? OP_LOOP : r);
      repeat (8) begin
         r = 8'($urandom);
         send_byte(r);
      end
      drain();

      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
